### rtl/selective_segment_upload_scheduler_defines.svh
// Assertion helpers; the including module supplies clk and rst_n.
`ifndef SELECTIVE_SEGMENT_UPLOAD_SCHEDULER_DEFINES_SVH
`define SELECTIVE_SEGMENT_UPLOAD_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define SSUS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SSUS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/ssus_pkg.sv
`default_nettype none
package ssus_pkg;

    localparam int MAX_SEGMENTS_DEF = 256;
    localparam int SEG_W            = 9;
    localparam int BYTE_W           = 16;
    localparam int OFF_W            = BYTE_W + SEG_W;
    localparam int WORD_W           = 64;
    localparam int WORD_SH          = 6;
    localparam int SINCE_W          = 4;
    localparam int MAP_INTERVAL     = 10;
    localparam int RESEND_MAX       = 32767;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_W            = 16;
    localparam int S_TDATA_W        = 72;
    localparam int M_TDATA_W        = 80;

    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_UPLOAD_BYTES   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        ACT_NEXT  = 2'd0,
        ACT_MAP   = 2'd1,
        ACT_START = 2'd2,
        ACT_ABORT = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_CREATE  = 2'd1,
        PH_SEND    = 2'd2,
        PH_WAITMAP = 2'd3
    } phase_t;

    typedef enum logic [2:0] {
        KIND_NONE    = 3'd0,
        KIND_SEND    = 3'd1,
        KIND_REQMAP  = 3'd2,
        KIND_DONE    = 3'd3,
        KIND_REFUSED = 3'd4,
        KIND_ABORTED = 3'd5
    } kind_t;

    typedef enum logic [3:0] {
        OP_NOP      = 4'd0,
        OP_FWD_INIT = 4'd1,
        OP_GAP_INIT = 4'd2,
        OP_SCAN     = 4'd3,
        OP_MUL      = 4'd4,
        OP_CALC     = 4'd5,
        OP_SEND     = 4'd6,
        OP_DONE     = 4'd7,
        OP_REQMAP   = 4'd8,
        OP_SIMPLE   = 4'd9
    } op_t;

    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_REQ   = 3'd2,
        C_NOT_NEXT = 3'd3,
        C_HIT      = 3'd4,
        C_MORE     = 3'd5
    } cond_t;

    typedef enum logic [3:0] {
        ST_FETCH    = 4'd0,
        ST_DECODE   = 4'd1,
        ST_FWD_INIT = 4'd2,
        ST_FWD_SCAN = 4'd3,
        ST_FWD_HIT  = 4'd4,
        ST_FWD_MORE = 4'd5,
        ST_GAP_INIT = 4'd6,
        ST_GAP_SCAN = 4'd7,
        ST_GAP_HIT  = 4'd8,
        ST_GAP_MORE = 4'd9,
        ST_DONE     = 4'd10,
        ST_REQMAP   = 4'd11,
        ST_MUL      = 4'd12,
        ST_CALC     = 4'd13,
        ST_SEND     = 4'd14,
        ST_SIMPLE   = 4'd15
    } step_t;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
        logic  ready;
        logic  hold;
    } ctrl_t;

    // control store
    function automatic ctrl_t ucode(input step_t s);
        ctrl_t c;
        c = '{op: OP_NOP, cond: C_NEVER, target: ST_FETCH, ready: 1'b0, hold: 1'b0};
        unique case (s)
            ST_FETCH:
            begin
                c.ready  = 1'b1;
                c.cond   = C_NO_REQ;
                c.target = ST_FETCH;
            end
            ST_DECODE:
            begin
                c.cond   = C_NOT_NEXT;
                c.target = ST_SIMPLE;
            end
            ST_FWD_INIT: c.op = OP_FWD_INIT;
            ST_FWD_SCAN: c.op = OP_SCAN;
            ST_FWD_HIT:
            begin
                c.cond   = C_HIT;
                c.target = ST_MUL;
            end
            ST_FWD_MORE:
            begin
                c.cond   = C_MORE;
                c.target = ST_FWD_SCAN;
            end
            ST_GAP_INIT: c.op = OP_GAP_INIT;
            ST_GAP_SCAN: c.op = OP_SCAN;
            ST_GAP_HIT:
            begin
                c.cond   = C_HIT;
                c.target = ST_REQMAP;
            end
            ST_GAP_MORE:
            begin
                c.cond   = C_MORE;
                c.target = ST_GAP_SCAN;
            end
            ST_DONE:
            begin
                c.op   = OP_DONE;
                c.hold = 1'b1;
                c.cond = C_ALWAYS;
            end
            ST_REQMAP:
            begin
                c.op   = OP_REQMAP;
                c.hold = 1'b1;
                c.cond = C_ALWAYS;
            end
            ST_MUL:  c.op = OP_MUL;
            ST_CALC: c.op = OP_CALC;
            ST_SEND:
            begin
                c.op   = OP_SEND;
                c.hold = 1'b1;
                c.cond = C_ALWAYS;
            end
            ST_SIMPLE:
            begin
                c.op   = OP_SIMPLE;
                c.hold = 1'b1;
                c.cond = C_ALWAYS;
            end
        endcase
        return c;
    endfunction

    // lowest set bit
    function automatic logic [WORD_SH-1:0] first_set(input logic [WORD_W-1:0] v);
        logic [WORD_SH-1:0] r;
        r = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
        begin
            if (v[b])
            begin
                r = WORD_SH'(b);
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### rtl/selective_segment_upload_scheduler.sv
// channel  dir  tdata                                         tuser      tlast
// s_*      in   create_ok, map_word, map_index (72b)          action     map_last
// m_*      out  segment_number, seg_offset, seg_length,       kind       -
//               want_map, bytes_sent, resend_total, phase_now (80b)
// cfg_*    in   write enable, index, data; no read-back
//
// Map, start and abort requests go from decode to a simple execute step that loads the result.
// Next-segment requests step a 64-bit scan unit one map word at a time, through
// scan, hit and more steps; a gap found goes on to multiply, calc and send, and a
// full rescan of up to 4 words follows when nothing lies ahead.
// Reset clears the control, upload, map and configuration state at once; no clearing pass.
// The final step of each request holds while the output register is full.
`default_nettype none
module selective_segment_upload_scheduler
    import ssus_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // create_ok, map_word[64], map_index[2]
    input  wire logic [1:0]           s_tuser,   // action
    input  wire logic                 s_tlast,   // map_last
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // segment_number, seg_offset, seg_length,
                                                 // want_map, bytes_sent, resend_total,
                                                 // phase_now, zero pad
    output logic [2:0]                m_tuser,   // kind
    input  wire logic                 cfg_write,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

`include "selective_segment_upload_scheduler_defines.svh"

    localparam int MAP_IDX_W = (MAX_SEGMENTS > WORD_W) ?
                               $clog2((MAX_SEGMENTS + WORD_W - 1) / WORD_W) : 1;
    localparam int MAP_WORDS = 1 << MAP_IDX_W;
    localparam logic [MAP_IDX_W-1:0] PTR_LAST = MAP_IDX_W'(MAP_WORDS - 1);

    // configuration
    logic [SEG_W-1:0]  seg_count_reg;
    logic [BYTE_W-1:0] seg_bytes_reg;
    logic [BYTE_W-1:0] upload_bytes_reg;
    logic [BYTE_W-1:0] limit_reg;

    // sequencer
    step_t pc_reg, pc_next;
    ctrl_t ctrl;
    logic  out_free;
    logic  exec;
    logic  take;
    logic  out_load;

    // latched request
    action_t              item_action_reg;
    logic                 item_ok_reg;
    logic [WORD_W-1:0]    item_word_reg;
    logic [1:0]           item_index_reg;
    logic                 item_last_reg;

    // upload state
    logic [WORD_W-1:0]   map_reg [MAP_WORDS];
    logic [WORD_W-1:0]   map_next [MAP_WORDS];
    phase_t              phase_reg, phase_next;
    logic [SEG_W-1:0]    scan_pos_reg, scan_pos_next;
    logic [SINCE_W-1:0]  since_reg, since_next;
    logic [BYTE_W-1:0]   prog_reg, prog_next;
    logic signed [15:0]  resend_reg, resend_next;

    // scan and send datapath
    logic [MAP_IDX_W-1:0] ptr_reg, ptr_next;
    logic [WORD_SH-1:0]   lo_off_reg, lo_off_next;
    logic                 void_reg, void_next;
    logic                 hit_reg, hit_next;
    logic                 more_reg, more_next;
    logic [SEG_W-1:0]     hit_idx_reg, hit_idx_next;
    logic [OFF_W-1:0]     off_reg, off_next;
    logic                 last_reg, last_next;
    logic [BYTE_W-1:0]    cnt_reg, cnt_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    kind_t              out_kind_reg, out_kind_next;
    logic [SEG_W-1:0]   out_seg_reg, out_seg_next;
    logic [BYTE_W-1:0]  out_off_reg, out_off_next;
    logic [BYTE_W-1:0]  out_cnt_reg, out_cnt_next;
    logic               out_want_reg, out_want_next;
    logic [BYTE_W-1:0]  out_prog_reg, out_prog_next;
    logic [15:0]        out_resend_reg, out_resend_next;
    phase_t             out_phase_reg, out_phase_next;

    // combinational helpers
    logic [SEG_W-1:0]   n_active;
    logic [2:0]         n_word;
    logic [2:0]         ptr_ext;
    logic [WORD_W-1:0]  scan_word;
    logic [WORD_W-1:0]  hi_mask;
    logic [WORD_W-1:0]  lo_mask;
    logic [WORD_W-1:0]  cand;
    logic [SEG_W-1:0]   next_base;
    logic [OFF_W:0]     end_sum;
    logic [BYTE_W:0]    prog_sum;
    logic [BYTE_W-1:0]  prog_sat;
    logic [SINCE_W:0]   since_inc;
    logic signed [15:0] resend_base;
    logic signed [15:0] resend_step;

    assign ctrl     = ucode(pc_reg);
    assign out_free = !out_valid_reg || m_tready;
    assign exec     = !(ctrl.hold && !out_free);
    assign out_load = ctrl.hold && out_free;
    assign s_tready = ctrl.ready;

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {4'd0, out_phase_reg, out_resend_reg, out_prog_reg, out_want_reg,
                       out_cnt_reg, out_off_reg, out_seg_reg};

    // configuration port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_count_reg    <= '0;
            seg_bytes_reg    <= BYTE_W'(1);
            upload_bytes_reg <= '0;
            limit_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_SEGMENT_COUNT:  seg_count_reg    <= cfg_data[SEG_W-1:0];
                CFG_SEGMENT_BYTES:  seg_bytes_reg    <= cfg_data[BYTE_W-1:0];
                CFG_UPLOAD_BYTES:   upload_bytes_reg <= cfg_data[BYTE_W-1:0];
                CFG_PROGRESS_LIMIT: limit_reg        <= cfg_data[BYTE_W-1:0];
                default:            ;
            endcase
        end
    end

    // scan unit: one map word per pass
    assign n_active  = (seg_count_reg > SEG_W'(MAX_SEGMENTS)) ? SEG_W'(MAX_SEGMENTS)
                                                              : seg_count_reg;
    assign n_word    = n_active[SEG_W-1:WORD_SH];
    assign ptr_ext   = 3'(ptr_reg);
    assign scan_word = map_reg[ptr_reg];
    assign lo_mask   = {WORD_W{1'b1}} << lo_off_reg;
    assign cand      = ~scan_word & hi_mask & lo_mask & {WORD_W{!void_reg}};
    assign next_base = SEG_W'(SEG_W'(ptr_reg) + SEG_W'(1)) << WORD_SH;

    always_comb
    begin
        if (ptr_ext < n_word)
        begin
            hi_mask = {WORD_W{1'b1}};
        end
        else if (ptr_ext == n_word)
        begin
            hi_mask = ~({WORD_W{1'b1}} << n_active[WORD_SH-1:0]);
        end
        else
        begin
            hi_mask = '0;
        end
    end

    // send arithmetic
    assign end_sum     = (OFF_W+1)'(off_reg) + (OFF_W+1)'(seg_bytes_reg);
    assign prog_sum    = (BYTE_W+1)'(prog_reg) + (BYTE_W+1)'(cnt_reg);
    assign prog_sat    = (prog_sum > (BYTE_W+1)'(limit_reg)) ? limit_reg
                                                             : prog_sum[BYTE_W-1:0];
    assign since_inc   = (SINCE_W+1)'(since_reg) + (SINCE_W+1)'(1);
    assign resend_base = (last_reg && resend_reg < 0) ? 16'sd0 : resend_reg;
    assign resend_step = (resend_base >= 0 && resend_base < 16'(RESEND_MAX))
                         ? resend_base + 16'sd1 : resend_base;

    // sequencer
    always_comb
    begin
        unique case (ctrl.cond)
            C_NEVER:    take = 1'b0;
            C_ALWAYS:   take = 1'b1;
            C_NO_REQ:   take = !s_tvalid;
            C_NOT_NEXT: take = !(item_action_reg == ACT_NEXT && phase_reg == PH_SEND);
            C_HIT:      take = hit_reg;
            C_MORE:     take = more_reg;
            default:    take = 1'b0;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (exec)
        begin
            if (take)
            begin
                pc_next = ctrl.target;
            end
            else
            begin
                pc_next = step_t'(4'(pc_reg) + 4'd1);
            end
        end
    end

    // datapath
    always_comb
    begin
        map_next        = map_reg;
        phase_next      = phase_reg;
        scan_pos_next   = scan_pos_reg;
        since_next      = since_reg;
        prog_next       = prog_reg;
        resend_next     = resend_reg;
        ptr_next        = ptr_reg;
        lo_off_next     = lo_off_reg;
        void_next       = void_reg;
        hit_next        = hit_reg;
        more_next       = more_reg;
        hit_idx_next    = hit_idx_reg;
        off_next        = off_reg;
        last_next       = last_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_seg_next    = out_seg_reg;
        out_off_next    = out_off_reg;
        out_cnt_next    = out_cnt_reg;
        out_want_next   = out_want_reg;
        out_prog_next   = out_prog_reg;
        out_resend_next = out_resend_reg;
        out_phase_next  = out_phase_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_kind_next  = KIND_NONE;
            out_seg_next   = '0;
            out_off_next   = '0;
            out_cnt_next   = '0;
            out_want_next  = 1'b0;
        end

        if (exec)
        begin
            unique case (ctrl.op)
                OP_NOP: ;
                OP_FWD_INIT:
                begin
                    ptr_next    = scan_pos_reg[MAP_IDX_W+WORD_SH-1:WORD_SH];
                    lo_off_next = scan_pos_reg[WORD_SH-1:0];
                    void_next   = scan_pos_reg >= n_active;
                end
                OP_GAP_INIT:
                begin
                    ptr_next    = '0;
                    lo_off_next = '0;
                    void_next   = 1'b0;
                end
                OP_SCAN:
                begin
                    hit_next     = |cand;
                    hit_idx_next = SEG_W'({ptr_reg, first_set(cand)});
                    more_next    = !void_reg && ptr_reg != PTR_LAST && next_base < n_active;
                    ptr_next     = ptr_reg + MAP_IDX_W'(1);
                    lo_off_next  = '0;
                end
                OP_MUL:
                begin
                    off_next = OFF_W'(seg_bytes_reg) * OFF_W'(hit_idx_reg);
                end
                OP_CALC:
                begin
                    last_next = end_sum >= (OFF_W+1)'(upload_bytes_reg);
                    if (end_sum >= (OFF_W+1)'(upload_bytes_reg))
                    begin
                        cnt_next = (off_reg < OFF_W'(upload_bytes_reg))
                                   ? BYTE_W'(OFF_W'(upload_bytes_reg) - off_reg) : '0;
                    end
                    else
                    begin
                        cnt_next = seg_bytes_reg;
                    end
                end
                OP_SEND:
                begin
                    prog_next     = prog_sat;
                    resend_next   = resend_step;
                    out_kind_next = KIND_SEND;
                    out_seg_next  = hit_idx_reg + SEG_W'(1);
                    out_off_next  = off_reg[BYTE_W-1:0];
                    out_cnt_next  = cnt_reg;
                    if (last_reg)
                    begin
                        scan_pos_next = '0;
                        since_next    = '0;
                        phase_next    = PH_WAITMAP;
                        out_want_next = 1'b1;
                    end
                    else
                    begin
                        scan_pos_next = hit_idx_reg + SEG_W'(1);
                        if (since_inc >= (SINCE_W+1)'(MAP_INTERVAL))
                        begin
                            since_next    = '0;
                            phase_next    = PH_WAITMAP;
                            out_want_next = 1'b1;
                        end
                        else
                        begin
                            since_next = since_inc[SINCE_W-1:0];
                        end
                    end
                end
                OP_DONE:
                begin
                    phase_next    = PH_IDLE;
                    out_kind_next = KIND_DONE;
                end
                OP_REQMAP:
                begin
                    scan_pos_next = '0;
                    phase_next    = PH_WAITMAP;
                    out_kind_next = KIND_REQMAP;
                end
                OP_SIMPLE:
                begin
                    unique case (item_action_reg)
                        ACT_NEXT: ;
                        ACT_MAP:
                        begin
                            if (phase_reg == PH_CREATE && !item_ok_reg)
                            begin
                                phase_next    = PH_IDLE;
                                out_kind_next = KIND_REFUSED;
                            end
                            else if (phase_reg == PH_CREATE || phase_reg == PH_WAITMAP)
                            begin
                                if ({1'b0, item_index_reg} < 3'(MAP_WORDS))
                                begin
                                    map_next[item_index_reg[MAP_IDX_W-1:0]] = item_word_reg;
                                end
                                if (item_last_reg)
                                begin
                                    phase_next = PH_SEND;
                                end
                            end
                        end
                        ACT_START:
                        begin
                            if (phase_reg == PH_IDLE)
                            begin
                                for (int w = 0; w < MAP_WORDS; w++)
                                begin
                                    map_next[w] = '0;
                                end
                                scan_pos_next = '0;
                                since_next    = '0;
                                prog_next     = '0;
                                resend_next   = -16'sd1;
                                phase_next    = PH_CREATE;
                            end
                        end
                        ACT_ABORT:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                phase_next    = PH_IDLE;
                                out_kind_next = KIND_ABORTED;
                            end
                        end
                    endcase
                end
                default: ;
            endcase
        end

        if (out_load)
        begin
            out_prog_next   = prog_next;
            out_resend_next = resend_next;
            out_phase_next  = phase_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_FETCH;
            phase_reg     <= PH_IDLE;
            scan_pos_reg  <= '0;
            since_reg     <= '0;
            prog_reg      <= '0;
            resend_reg    <= -16'sd1;
            out_valid_reg <= 1'b0;
            for (int w = 0; w < MAP_WORDS; w++)
            begin
                map_reg[w] <= '0;
            end
        end
        else
        begin
            pc_reg        <= pc_next;
            phase_reg     <= phase_next;
            scan_pos_reg  <= scan_pos_next;
            since_reg     <= since_next;
            prog_reg      <= prog_next;
            resend_reg    <= resend_next;
            out_valid_reg <= out_valid_next;
            map_reg       <= map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            item_action_reg <= action_t'(s_tuser);
            item_ok_reg     <= s_tdata[0];
            item_word_reg   <= s_tdata[WORD_W:1];
            item_index_reg  <= s_tdata[WORD_W+2:WORD_W+1];
            item_last_reg   <= s_tlast;
        end
        ptr_reg         <= ptr_next;
        lo_off_reg      <= lo_off_next;
        void_reg        <= void_next;
        hit_reg         <= hit_next;
        more_reg        <= more_next;
        hit_idx_reg     <= hit_idx_next;
        off_reg         <= off_next;
        last_reg        <= last_next;
        cnt_reg         <= cnt_next;
        out_kind_reg    <= out_kind_next;
        out_seg_reg     <= out_seg_next;
        out_off_reg     <= out_off_next;
        out_cnt_reg     <= out_cnt_next;
        out_want_reg    <= out_want_next;
        out_prog_reg    <= out_prog_next;
        out_resend_reg  <= out_resend_next;
        out_phase_reg   <= out_phase_next;
    end

    `SSUS_ASSERT_NEXT(a_accept_decodes, s_tvalid && s_tready, pc_reg == ST_DECODE,
        "accepted request not decoded")
    `SSUS_ASSERT_IMPL(a_scan_while_sending, pc_reg == ST_FWD_SCAN, phase_reg == PH_SEND,
        "forward scan outside sending phase")
    `SSUS_ASSERT_IMPL(a_send_in_range, pc_reg == ST_SEND, hit_idx_reg < n_active,
        "segment beyond active count")
    `SSUS_ASSERT_IMPL(a_resend_floor, 1'b1,
        resend_reg >= -16'sd1, "resend counter below minus one")

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
    import ssus_pkg::*;

    localparam int SEGS       = MAX_SEGMENTS_DEF;
    localparam int QUIET_MAX  = 3000;
    localparam int SETTLE     = 40;
    localparam int LONG_STALL = 300;
    localparam int PHASES     = 10;
    localparam int PER_PHASE  = 80;

    typedef struct packed {
        action_t     act;
        logic        create_ok;
        logic [63:0] word;
        logic [1:0]  idx;
        logic        last;
    } upload_cmd_t;

    typedef struct packed {
        kind_t       kind;
        logic [8:0]  seg_num;
        logic [15:0] offset;
        logic [15:0] count;
        logic        want_map;
        logic [15:0] sent;
        logic [15:0] resend;
        phase_t      phase;
    } upload_report_t;

    typedef struct {
        logic [SEGS-1:0] acked;
        phase_t          phase;
        int unsigned     scan;
        int unsigned     since;
        int unsigned     progress;
        int              resend;
    } scheduler_state_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic s_tlast = 1'b0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [2:0] m_tuser;
    logic cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // register copies
    int unsigned seg_count_reg = 0;
    int unsigned seg_bytes_reg = 1;
    int unsigned upload_bytes_reg = 0;
    int unsigned progress_limit_reg = 0;

    scheduler_state_t plan_st;
    scheduler_state_t live_st;
    upload_cmd_t pending_cmds[$];
    upload_report_t due_reports[$];
    upload_cmd_t cur_cmd;

    int fail_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int stall_request = 0;
    int stall_seen = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    selective_segment_upload_scheduler dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void clear_state(ref scheduler_state_t st);
        st.acked    = '0;
        st.phase    = PH_IDLE;
        st.scan     = 0;
        st.since    = 0;
        st.progress = 0;
        st.resend   = -1;
    endfunction

    function automatic void store_map_word(ref scheduler_state_t st, input upload_cmd_t c);
        int unsigned pos;
        for (int b = 0; b < 64; b++)
        begin
            pos = c.idx * 64 + b;
            if (pos < SEGS)
                st.acked[pos] = c.word[b];
        end
    endfunction

    // next-segment scan: first gap from the scan position, else full rescan
    function automatic void scan_next(ref scheduler_state_t st, inout upload_report_t r);
        int unsigned n, hit, off, cnt, sum;
        bit found;
        bit gap;
        n = seg_count_reg > SEGS ? SEGS : seg_count_reg;
        found = 0;
        gap = 0;
        hit = 0;
        for (int unsigned k = st.scan; k < n; k++)
        begin
            if (!found && !st.acked[k])
            begin
                found = 1;
                hit = k;
            end
        end
        if (found)
        begin
            off = seg_bytes_reg * hit;
            st.scan = hit + 1;
            if (off + seg_bytes_reg >= upload_bytes_reg)
            begin
                cnt = off < upload_bytes_reg ? upload_bytes_reg - off : 0;
                st.scan = 0;
                st.since = 0;
                st.phase = PH_WAITMAP;
                r.want_map = 1'b1;
                if (st.resend < 0)
                    st.resend = 0;
            end
            else
            begin
                cnt = seg_bytes_reg;
                st.since++;
                if (st.since >= MAP_INTERVAL)
                begin
                    st.since = 0;
                    st.phase = PH_WAITMAP;
                    r.want_map = 1'b1;
                end
            end
            sum = st.progress + cnt;
            st.progress = sum > progress_limit_reg ? progress_limit_reg : sum;
            if (st.resend >= 0 && st.resend < RESEND_MAX)
                st.resend++;
            r.kind    = KIND_SEND;
            r.seg_num = 9'(hit + 1);
            r.offset  = 16'(off);
            r.count   = 16'(cnt);
            return;
        end
        for (int unsigned k = 0; k < n; k++)
            if (!st.acked[k])
                gap = 1;
        if (gap)
        begin
            st.scan = 0;
            st.phase = PH_WAITMAP;
            r.kind = KIND_REQMAP;
        end
        else
        begin
            st.phase = PH_IDLE;
            r.kind = KIND_DONE;
        end
    endfunction

    function automatic upload_report_t schedule_step(ref scheduler_state_t st,
                                                     input upload_cmd_t c);
        upload_report_t r;
        r = '0;
        r.kind = KIND_NONE;
        case (c.act)
            ACT_NEXT:
            begin
                if (st.phase == PH_SEND)
                    scan_next(st, r);
            end
            ACT_MAP:
            begin
                if (st.phase == PH_CREATE && !c.create_ok)
                begin
                    st.phase = PH_IDLE;
                    r.kind = KIND_REFUSED;
                end
                else if (st.phase == PH_CREATE || st.phase == PH_WAITMAP)
                begin
                    store_map_word(st, c);
                    if (c.last)
                        st.phase = PH_SEND;
                end
            end
            ACT_START:
            begin
                if (st.phase == PH_IDLE)
                begin
                    clear_state(st);
                    st.phase = PH_CREATE;
                end
            end
            default:
            begin
                if (st.phase != PH_IDLE)
                begin
                    st.phase = PH_IDLE;
                    r.kind = KIND_ABORTED;
                end
            end
        endcase
        r.sent   = 16'(st.progress);
        r.resend = 16'(st.resend);
        r.phase  = st.phase;
        return r;
    endfunction

    function automatic upload_cmd_t make_cmd(action_t a, logic ok, logic [63:0] w,
                                             logic [1:0] idx, logic last);
        upload_cmd_t c;
        c.act = a;
        c.create_ok = ok;
        c.word = w;
        c.idx = idx;
        c.last = last;
        return c;
    endfunction

    function automatic logic [63:0] map_pattern();
        logic [63:0] w;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            w = '0;
        else if (r < 45)
            w = '1;
        else if (r < 75)
        begin
            w = '1;
            repeat ($urandom_range(1, 3))
                w[$urandom_range(0, 63)] = 1'b0;
        end
        else if (r < 90)
            w = {$urandom, $urandom};
        else
            w = {$urandom, $urandom} & {$urandom, $urandom};
        return w;
    endfunction

    // random fields; the caller picks an action the current phase ignores
    function automatic upload_cmd_t ignored_cmd(action_t a, action_t b);
        upload_cmd_t c;
        c = make_cmd($urandom_range(0, 1) ? a : b, 1'($urandom), {$urandom, $urandom},
                     2'($urandom), 1'($urandom));
        return c;
    endfunction

    task automatic pick_cmd(output upload_cmd_t c, output bit noise);
        int r;
        r = $urandom_range(0, 99);
        noise = 0;
        case (plan_st.phase)
            PH_IDLE:
            begin
                if (r < 85)
                    c = make_cmd(ACT_START, 1'($urandom), {$urandom, $urandom},
                                 2'($urandom), 1'($urandom));
                else
                begin
                    c = ignored_cmd(ACT_NEXT, ACT_MAP);
                    if (r > 95)
                        c.act = ACT_ABORT;
                    noise = 1;
                end
            end
            PH_CREATE:
            begin
                if (r < 8)
                    c = make_cmd(ACT_MAP, 1'b0, {$urandom, $urandom}, 2'($urandom),
                                 1'($urandom));
                else if (r < 12)
                    c = make_cmd(ACT_ABORT, 1'($urandom), {$urandom, $urandom},
                                 2'($urandom), 1'($urandom));
                else if (r < 16)
                begin
                    c = ignored_cmd(ACT_NEXT, ACT_START);
                    noise = 1;
                end
                else
                    c = make_cmd(ACT_MAP, 1'b1, map_pattern(), 2'($urandom),
                                 $urandom_range(0, 2) == 0);
            end
            PH_SEND:
            begin
                if (r < 3)
                    c = make_cmd(ACT_ABORT, 1'($urandom), {$urandom, $urandom},
                                 2'($urandom), 1'($urandom));
                else if (r < 8)
                begin
                    c = ignored_cmd(ACT_START, ACT_MAP);
                    noise = 1;
                end
                else
                    c = make_cmd(ACT_NEXT, 1'($urandom), {$urandom, $urandom},
                                 2'($urandom), 1'($urandom));
            end
            default:
            begin
                if (r < 4)
                    c = make_cmd(ACT_ABORT, 1'($urandom), {$urandom, $urandom},
                                 2'($urandom), 1'($urandom));
                else if (r < 8)
                begin
                    c = ignored_cmd(ACT_NEXT, ACT_START);
                    noise = 1;
                end
                else
                    c = make_cmd(ACT_MAP, 1'($urandom), map_pattern(), 2'($urandom),
                                 $urandom_range(0, 2) == 0);
            end
        endcase
    endtask

    task automatic queue_cmd(input upload_cmd_t c);
        void'(schedule_step(plan_st, c));
        pending_cmds.push_back(c);
    endtask

    task automatic write_config(input int unsigned cnt, seg, upl, lim);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= CFG_SEGMENT_COUNT;
        cfg_data  <= 16'(cnt);
        @(posedge clk);
        cfg_index <= CFG_SEGMENT_BYTES;
        cfg_data  <= 16'(seg);
        @(posedge clk);
        cfg_index <= CFG_UPLOAD_BYTES;
        cfg_data  <= 16'(upl);
        @(posedge clk);
        cfg_index <= CFG_PROGRESS_LIMIT;
        cfg_data  <= 16'(lim);
        @(posedge clk);
        cfg_write <= 1'b0;
        seg_count_reg      = cnt & 32'h1FF;
        seg_bytes_reg      = seg & 32'hFFFF;
        upload_bytes_reg   = upl & 32'hFFFF;
        progress_limit_reg = lim & 32'hFFFF;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_cmds.size() != 0 || s_tvalid || due_reports.size() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] exp, got);
        if (exp !== got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp, got);
            fail_count++;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        upload_report_t rpt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                rpt = schedule_step(live_st, cur_cmd);
                due_reports.push_back(rpt);
            end
            if (!s_tvalid || s_tready)
            begin
                if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= gap_pct)
                begin
                    cur_cmd = pending_cmds.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, cur_cmd.idx, cur_cmd.word, cur_cmd.create_ok};
                    s_tuser  <= cur_cmd.act;
                    s_tlast  <= cur_cmd.last;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin : watch_reports
        upload_report_t exp;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (due_reports.size() == 0)
                begin
                    $error("unexpected result: kind %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    exp = due_reports.pop_front();
                    check_field("kind", 16'(exp.kind), 16'(m_tuser));
                    check_field("segment_number", 16'(exp.seg_num), 16'(m_tdata[8:0]));
                    check_field("seg_offset", exp.offset, m_tdata[24:9]);
                    check_field("seg_length", exp.count, m_tdata[40:25]);
                    check_field("want_map", 16'(exp.want_map), 16'(m_tdata[41]));
                    check_field("bytes_sent", exp.sent, m_tdata[57:42]);
                    check_field("resend_total", exp.resend, m_tdata[73:58]);
                    check_field("phase_now", 16'(exp.phase), 16'(m_tdata[75:74]));
                end
            end
            if (stall_seen != stall_request)
            begin
                stall_seen = stall_request;
                stall_left = LONG_STALL;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= $urandom_range(0, 99) >= stall_pct;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_MAX)
            begin
                $display("testbench failed");
                $finish;
            end
        end
    end

    initial
    begin : stimulus
        upload_cmd_t c;
        bit noise;
        int useful;
        int unsigned cnt, seg, upl, lim, full;
        clear_state(plan_st);
        clear_state(live_st);
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: ignored actions, creation, skips, last segment, rescan, done,
        // refusal and abort
        write_config(4, 100, 350, 200);
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, '1, 2'd0, 1'b1));
        queue_cmd(make_cmd(ACT_ABORT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_START, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_START, 1'b1, '1, 2'd3, 1'b1));
        queue_cmd(make_cmd(ACT_NEXT, 1'b1, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, '1, 2'd3, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, 64'hC, 2'd0, 1'b1));
        queue_cmd(make_cmd(ACT_START, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, '1, 2'd0, 1'b1));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b0, 64'h5, 2'd0, 1'b1));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, 64'hF, 2'd0, 1'b1));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_START, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b0, '1, 2'd1, 1'b1));
        queue_cmd(make_cmd(ACT_START, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_MAP, 1'b1, '0, 2'd2, 1'b1));
        queue_cmd(make_cmd(ACT_NEXT, 1'b0, '0, 2'd0, 1'b0));
        queue_cmd(make_cmd(ACT_ABORT, 1'b1, '1, 2'd3, 1'b1));
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p == 0)
            begin
                cnt = SEGS;
                seg = 1;
                upl = 65535;
                lim = 65535;
            end
            else if (p == 1)
            begin
                cnt = 0;
                seg = 65535;
                upl = 0;
                lim = 0;
            end
            else
            begin
                case ($urandom_range(0, 5))
                    0: cnt = 1;
                    1: cnt = SEGS;
                    2: cnt = $urandom_range(0, SEGS);
                    default: cnt = $urandom_range(1, 16);
                endcase
                case ($urandom_range(0, 3))
                    0: seg = 1;
                    1: seg = 65535;
                    2: seg = $urandom_range(1, 65535);
                    default: seg = $urandom_range(1, 300);
                endcase
                full = cnt * seg;
                case ($urandom_range(0, 5))
                    0: upl = 0;
                    1: upl = 65535;
                    2: upl = $urandom_range(0, 65535);
                    default:
                        if (full == 0 || full > 65535)
                            upl = $urandom_range(0, 65535);
                        else
                            upl = full - $urandom_range(0, seg - 1);
                endcase
                case ($urandom_range(0, 3))
                    0: lim = 0;
                    1: lim = 65535;
                    2: lim = $urandom_range(0, 65535);
                    default: lim = upl;
                endcase
            end
            write_config(cnt, seg, upl, lim);

            case (p % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 65; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 65; end
                default: begin gap_pct = 8; stall_pct = 8; end
            endcase

            useful = 0;
            while (useful < PER_PHASE)
            begin
                pick_cmd(c, noise);
                queue_cmd(c);
                if (!noise)
                    useful++;
            end
            // hold results off while requests keep coming
            if (p == 2)
                stall_request++;
            wait_drained();
        end

        if (fail_count == 0 && due_reports.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

### files.f
+incdir+rtl
rtl/ssus_pkg.sv
rtl/selective_segment_upload_scheduler.sv
sim/testbench.sv
